/* design/ita_pkg.sv */
`timescale 1ns / 1ps

package ita_pkg;

    // word width of the formatted value
    localparam int VALUE_BITS = 32;

    // compare width leaves room for nine times the top power of ten
    localparam int CMP_W = VALUE_BITS + 4;

    // number of decimal digits needed for the widest unsigned value
    function automatic int calc_dec_digits();
        logic [127:0] lim;
        logic [127:0] p;
        int           n;
        lim = (128'd1 << VALUE_BITS) - 128'd1;
        p   = 128'd10;
        n   = 1;
        for (int i = 0; i < 40; i++)
        begin
            if (p <= lim)
            begin
                p = p * 128'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int DEC_DIGITS = calc_dec_digits();
    localparam int IDX_W      = $clog2(DEC_DIGITS);

    // multiples m * 10^k for every digit position k and m = 0..9
    typedef logic [DEC_DIGITS-1:0][9:0][CMP_W-1:0] mult_tab_t;

    function automatic mult_tab_t calc_mults();
        mult_tab_t        t;
        logic [CMP_W-1:0] p;
        p = CMP_W'(1);
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            for (int m = 0; m < 10; m++)
            begin
                t[k][m] = CMP_W'(p * CMP_W'(m));
            end
            p = CMP_W'(p * CMP_W'(10));
        end
        return t;
    endfunction

    localparam mult_tab_t MULTS = calc_mults();

    // conversion codes
    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } op_t;

    // ascii constants
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // command and result payloads
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        op_t                   opcode;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } result_t;

    // item state carried down the digit pipeline
    typedef struct packed {
        logic [VALUE_BITS-1:0]           rem;
        logic                            neg;
        op_t                             op;
        logic [DEC_DIGITS-1:0][3:0]      digits;
        logic [IDX_W-1:0]                lead;
        logic                            found;
    } pipe_t;

    // one digit value to its character
    function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            c = (upper ? CHAR_UPPER : CHAR_LOWER) + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* design/integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps
// first character passes the input register, digit stages, serializer and output register
// throughput: one character per cycle while the serializer holds a value; each
// value holds the output for its length, 1 to 11 characters, one character per transfer
// the digit pipeline keeps up to DEC_DIGITS + 2 values in flight; busy rises when it is full
// reset clears all valid bits at once; no clearing pass

module integer_to_ascii_formatter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ita_pkg::cmd_t      cmd,
    output logic               strobe,
    output ita_pkg::result_t   result
);

    localparam int D = ita_pkg::DEC_DIGITS;

    logic                      in_valid_reg;
    ita_pkg::pipe_t            in_data_reg;
    ita_pkg::pipe_t            in_data_next;
    logic                      accept;
    logic                      neg;

    logic [D:0]                chain_valid;
    logic [D:0]                chain_ready;
    ita_pkg::pipe_t            chain_data [D+1];

    // input stage: sign and magnitude
    assign neg = (cmd.opcode == ita_pkg::OP_SDEC) && cmd.value[ita_pkg::VALUE_BITS-1];

    always_comb
    begin
        in_data_next        = '0;
        in_data_next.rem    = neg ? (~cmd.value + 1'b1) : cmd.value;
        in_data_next.neg    = neg;
        in_data_next.op     = cmd.opcode;
    end

    assign busy   = in_valid_reg && !chain_ready[0];
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data_next;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    // one stage per digit position, most significant first
    for (genvar g = 0; g < D; g++)
    begin : g_digit
        ita_digit_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .digit_idx (ita_pkg::IDX_W'(D - 1 - g)),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .in_ready  (chain_ready[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1]),
            .out_ready (chain_ready[g+1])
        );
    end

    // character output
    ita_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[D]),
        .in_data  (chain_data[D]),
        .in_ready (chain_ready[D]),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

/* design/ita_digit_stage.sv */
`timescale 1ns / 1ps

module ita_digit_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [ita_pkg::IDX_W-1:0] digit_idx,
    input  logic                      in_valid,
    input  ita_pkg::pipe_t            in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output ita_pkg::pipe_t            out_data,
    input  logic                      out_ready
);

    logic                          valid_reg;
    ita_pkg::pipe_t                data_reg;
    ita_pkg::pipe_t                data_next;
    logic [ita_pkg::CMP_W-1:0]     rem_ext;
    logic [3:0]                    dec_d;
    logic [3:0]                    hex_d;
    logic [3:0]                    digit;
    logic                          is_hex;

    assign rem_ext = ita_pkg::CMP_W'(in_data.rem);
    assign is_hex  = (in_data.op == ita_pkg::OP_HEXL) || (in_data.op == ita_pkg::OP_HEXU);

    // decimal digit: how many multiples of this power of ten fit
    always_comb
    begin
        dec_d = 4'd0;
        for (int m = 1; m < 10; m++)
        begin
            if (rem_ext >= ita_pkg::MULTS[digit_idx][m])
            begin
                dec_d = 4'(m);
            end
        end
    end

    // hex digit is the nibble at this position
    assign hex_d = 4'(in_data.rem >> {digit_idx, 2'b00});
    assign digit = is_hex ? hex_d : dec_d;

    // remainder update, digit store and leading digit tracking
    always_comb
    begin
        data_next = in_data;
        if (!is_hex)
        begin
            data_next.rem = ita_pkg::VALUE_BITS'(rem_ext - ita_pkg::MULTS[digit_idx][dec_d]);
        end
        data_next.digits[digit_idx] = digit;
        if (!in_data.found && (digit != 4'd0))
        begin
            data_next.found = 1'b1;
            data_next.lead  = digit_idx;
        end
    end

    // stage holds while downstream is full
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/ita_serializer.sv */
`timescale 1ns / 1ps

module ita_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ita_pkg::pipe_t       in_data,
    output logic                 in_ready,
    output logic                 strobe,
    output ita_pkg::result_t     result
);

    logic                       valid_reg;
    logic                       sign_pend_reg;
    logic [ita_pkg::IDX_W-1:0]  pos_reg;
    ita_pkg::pipe_t             item_reg;
    logic                       strobe_reg;
    ita_pkg::result_t           result_reg;
    ita_pkg::result_t           result_next;
    logic                       finishing;
    logic                       load;
    logic [3:0]                 cur_digit;

    // last character of the held item is selected for the output register
    assign finishing = valid_reg && !sign_pend_reg && (pos_reg == '0);
    assign in_ready  = !valid_reg || finishing;
    assign load      = in_valid && in_ready;

    // control: sign first, then digits from the leading one down
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            sign_pend_reg <= 1'b0;
            pos_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= valid_reg;
            if (load)
            begin
                valid_reg     <= 1'b1;
                sign_pend_reg <= in_data.neg;
                pos_reg       <= in_data.lead;
            end
            else if (finishing)
            begin
                valid_reg <= 1'b0;
            end
            else if (valid_reg)
            begin
                if (sign_pend_reg)
                begin
                    sign_pend_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_data;
        end
    end

    // character for the current position
    assign cur_digit = item_reg.digits[pos_reg];

    always_comb
    begin
        if (sign_pend_reg)
        begin
            result_next.ascii_char = ita_pkg::CHAR_MINUS;
            result_next.last_char  = 1'b0;
        end
        else
        begin
            result_next.ascii_char = ita_pkg::digit_char(cur_digit,
                                         item_reg.op == ita_pkg::OP_HEXU);
            result_next.last_char  = (pos_reg == '0);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

/* verif/integer_to_ascii_formatter_test.sv */
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 198;
    localparam int DRAIN_CYCLES = ita_pkg::DEC_DIGITS + 12;

    // one directed row: an empty text means the predictor supplies it
    typedef struct {
        logic [ita_pkg::VALUE_BITS-1:0] value;
        ita_pkg::op_t                   opcode;
        string                          text;
    } vec_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    ita_pkg::cmd_t    cmd;
    logic             strobe;
    ita_pkg::result_t result;

    // characters expected from the block, oldest first
    ita_pkg::result_t pending_chars[$];
    logic [7:0]       text_buf[$];
    ita_pkg::result_t want;

    int cycles        = 0;
    int errors        = 0;
    int values_sent   = 0;
    int neg_sent      = 0;
    int chars_checked = 0;
    int idle_pct      = 0;

    vec_t dir_vecs[] = '{
        '{32'h0000_0000, ita_pkg::OP_SDEC, "0"},
        '{32'h0000_0000, ita_pkg::OP_UDEC, "0"},
        '{32'h0000_0000, ita_pkg::OP_HEXL, "0"},
        '{32'h0000_0000, ita_pkg::OP_HEXU, "0"},
        '{32'h8000_0000, ita_pkg::OP_SDEC, "-2147483648"},
        '{32'hFFFF_FFFF, ita_pkg::OP_SDEC, "-1"},
        '{32'h7FFF_FFFF, ita_pkg::OP_SDEC, "2147483647"},
        '{32'h0000_0001, ita_pkg::OP_SDEC, "1"},
        '{32'hFFFF_FFFF, ita_pkg::OP_UDEC, "4294967295"},
        '{32'h8000_0000, ita_pkg::OP_UDEC, "2147483648"},
        '{32'hFFFF_FFFF, ita_pkg::OP_HEXL, "ffffffff"},
        '{32'hFFFF_FFFF, ita_pkg::OP_HEXU, "FFFFFFFF"},
        '{32'h8000_0000, ita_pkg::OP_HEXL, "80000000"},
        '{32'hABCD_EF01, ita_pkg::OP_HEXL, "abcdef01"},
        '{32'hABCD_EF01, ita_pkg::OP_HEXU, "ABCDEF01"},
        '{32'h0000_0009, ita_pkg::OP_UDEC, "9"},
        '{32'h0000_000A, ita_pkg::OP_UDEC, "10"},
        '{32'd1000000000, ita_pkg::OP_UDEC, ""},
        '{32'd999999999, ita_pkg::OP_SDEC, ""},
        '{32'hF000_0000, ita_pkg::OP_SDEC, ""},
        '{32'h0000_000F, ita_pkg::OP_HEXU, ""},
        '{32'h0000_0010, ita_pkg::OP_HEXL, ""},
        '{32'd123456789, ita_pkg::OP_UDEC, ""},
        '{32'hDEAD_BEEF, ita_pkg::OP_SDEC, ""}
    };

    integer_to_ascii_formatter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // expected text of one value, most significant character first
    function automatic void render_word(logic [ita_pkg::VALUE_BITS-1:0] v, ita_pkg::op_t op);
        logic [ita_pkg::VALUE_BITS-1:0] mag;
        logic [ita_pkg::VALUE_BITS-1:0] base;
        logic [ita_pkg::VALUE_BITS-1:0] d;
        logic [7:0]                     c;
        logic                           neg;
        neg  = (op == ita_pkg::OP_SDEC) && v[ita_pkg::VALUE_BITS-1];
        mag  = neg ? (~v + 1'b1) : v;
        base = (op == ita_pkg::OP_HEXL || op == ita_pkg::OP_HEXU) ? 16 : 10;
        text_buf.delete();
        do
        begin
            d = mag % base;
            if (d < 10)
            begin
                c = ita_pkg::CHAR_ZERO + 8'(d);
            end
            else
            begin
                c = ((op == ita_pkg::OP_HEXU) ? ita_pkg::CHAR_UPPER : ita_pkg::CHAR_LOWER)
                    + 8'(d) - 8'd10;
            end
            text_buf.push_front(c);
            mag = mag / base;
        end
        while (mag != 0);
        if (neg)
        begin
            text_buf.push_front(ita_pkg::CHAR_MINUS);
        end
    endfunction

    // random value biased toward digit count and sign boundaries
    function automatic logic [ita_pkg::VALUE_BITS-1:0] pick_value();
        logic [ita_pkg::VALUE_BITS-1:0] v;
        logic [ita_pkg::VALUE_BITS-1:0] p;
        p = 1;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 20);
            2: v = $urandom() >> $urandom_range(0, ita_pkg::VALUE_BITS - 1);
            3: v = 32'h8000_0000 + $urandom_range(0, 4) - 2;
            4:
            begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            default: v = ~($urandom() >> $urandom_range(0, ita_pkg::VALUE_BITS - 1));
        endcase
        return v;
    endfunction

    // offer one value, wait for the transfer, then record its characters
    task automatic send_value(ita_pkg::cmd_t c, string text);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        if (text == "")
        begin
            render_word(c.value, c.opcode);
        end
        else
        begin
            text_buf.delete();
            for (int i = 0; i < text.len(); i++)
            begin
                text_buf.push_back(text[i]);
            end
        end
        foreach (text_buf[i])
        begin
            pending_chars.push_back('{ascii_char: text_buf[i],
                                      last_char: (i == text_buf.size() - 1)});
        end
        values_sent++;
        if (c.opcode == ita_pkg::OP_SDEC && c.value[ita_pkg::VALUE_BITS-1])
        begin
            neg_sent++;
        end
    endtask

    // result check and cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                errors++;
                $error("ascii_char: no transfer expected, got %h last_char %b",
                       result.ascii_char, result.last_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (result.ascii_char !== want.ascii_char)
                begin
                    errors++;
                    $error("ascii_char: expected %h, got %h",
                           want.ascii_char, result.ascii_char);
                end
                if (result.last_char !== want.last_char)
                begin
                    errors++;
                    $error("last_char: expected %b, got %b",
                           want.last_char, result.last_char);
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        ita_pkg::cmd_t c;
        int            phase_pct[3];
        phase_pct = '{0, 68, 36};
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back
        foreach (dir_vecs[i])
        begin
            c.value  = dir_vecs[i].value;
            c.opcode = dir_vecs[i].opcode;
            send_value(c, dir_vecs[i].text);
        end

        // random values; only the sender can idle, results cannot be held off
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_pct[ph];
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                c.value  = pick_value();
                c.opcode = ita_pkg::op_t'($urandom_range(0, 3));
                send_value(c, "");
            end
        end
        start <= 1'b0;

        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("formatted %0d values (%0d negative signed), %0d characters checked",
                 values_sent, neg_sent, chars_checked);
        $display("sender idle rates 0, 68 and 36 percent, all four conversions");
        if (errors == 0 && pending_chars.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
